// ===== sv/rig_pkg.sv =====
// Shared types and constants for the radical inverse generator.
// Holds the controller/datapath command and status structs and the reciprocal table.
// No dependencies.
package rig_pkg;

    localparam int FRAC_BITS  = 32;
    localparam int CNT_W      = $clog2(FRAC_BITS);
    localparam int RADIX_W    = 5;
    localparam int INDEX_W    = 31;
    localparam int FRACTION_W = 32;
    localparam int POW_W      = 36;
    localparam int PROD_W     = 63;
    localparam logic [RADIX_W-1:0] MIN_RADIX   = 5'd2;
    localparam logic [RADIX_W-1:0] RESET_RADIX = 5'd2;

    // floor(2^32 / b); the quotient estimate from it is low by at most one.
    localparam logic [31:0] RECIP_TBL [32] = '{
        32'd0, 32'd0,
        32'(64'h1_0000_0000 / 2),  32'(64'h1_0000_0000 / 3),
        32'(64'h1_0000_0000 / 4),  32'(64'h1_0000_0000 / 5),
        32'(64'h1_0000_0000 / 6),  32'(64'h1_0000_0000 / 7),
        32'(64'h1_0000_0000 / 8),  32'(64'h1_0000_0000 / 9),
        32'(64'h1_0000_0000 / 10), 32'(64'h1_0000_0000 / 11),
        32'(64'h1_0000_0000 / 12), 32'(64'h1_0000_0000 / 13),
        32'(64'h1_0000_0000 / 14), 32'(64'h1_0000_0000 / 15),
        32'(64'h1_0000_0000 / 16), 32'(64'h1_0000_0000 / 17),
        32'(64'h1_0000_0000 / 18), 32'(64'h1_0000_0000 / 19),
        32'(64'h1_0000_0000 / 20), 32'(64'h1_0000_0000 / 21),
        32'(64'h1_0000_0000 / 22), 32'(64'h1_0000_0000 / 23),
        32'(64'h1_0000_0000 / 24), 32'(64'h1_0000_0000 / 25),
        32'(64'h1_0000_0000 / 26), 32'(64'h1_0000_0000 / 27),
        32'(64'h1_0000_0000 / 28), 32'(64'h1_0000_0000 / 29),
        32'(64'h1_0000_0000 / 30), 32'(64'h1_0000_0000 / 31)
    };

    typedef struct packed {
        logic load;      // take a new index, clear the accumulators
        logic mul_en;    // first half of a digit step: reciprocal multiply
        logic digit_en;  // second half: correct quotient, append digit
        logic div_en;    // one bit of the fraction long division
    } t_rig_cmd;

    typedef struct packed {
        logic idx_zero;  // no digits left in the working index
    } t_rig_sts;

endpackage

// ===== sv/rig_ctrl.sv =====
// Controller state machine for the radical inverse generator.
// Sequences digit extraction and the fraction division; depends on rig_pkg.
module rig_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_valid,
    output rig_pkg::t_rig_cmd o_cmd,
    input  rig_pkg::t_rig_sts i_sts
);
    import rig_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIG_A,
        ST_DIG_B,
        ST_DIV
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIG_A;
                end
            end
            ST_DIG_A: begin
                if (i_sts.idx_zero) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end else begin
                    o_cmd.mul_en = 1'b1;
                    n_state      = ST_DIG_B;
                end
            end
            ST_DIG_B: begin
                o_cmd.digit_en = 1'b1;
                n_state        = ST_DIG_A;
            end
            ST_DIV: begin
                o_cmd.div_en = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FRAC_BITS - 1)) begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== sv/rig_dpath.sv =====
// Datapath of the radical inverse generator: radix register, digit step, long division.
// Driven by rig_ctrl commands; depends on rig_pkg.
module rig_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rig_pkg::RADIX_W-1:0]         i_cfg_data,
    input  logic [rig_pkg::INDEX_W-1:0]         i_index,
    input  rig_pkg::t_rig_cmd                   i_cmd,
    output rig_pkg::t_rig_sts                   o_sts,
    output logic [rig_pkg::FRACTION_W-1:0]      o_fraction
);
    import rig_pkg::*;

    logic [RADIX_W-1:0]   r_radix;
    logic [RADIX_W-1:0]   w_base;
    logic [31:0]          w_recip;

    logic [INDEX_W-1:0]   r_num;
    logic [PROD_W-1:0]    r_prod;
    logic [POW_W-1:0]     r_mir;
    logic [POW_W-1:0]     r_pow;
    logic [POW_W-1:0]     r_mir_b;
    logic [POW_W-1:0]     r_pow_b;
    logic [FRAC_BITS-1:0] r_quot;

    logic [INDEX_W-1:0]   w_q0;
    logic [INDEX_W-1:0]   w_q0_b;
    logic [INDEX_W-1:0]   w_rem0;
    logic                 w_corr;
    logic [RADIX_W-1:0]   w_digit;
    logic [POW_W:0]       w_shift;
    logic                 w_ge;

    // A radix of zero or one has no expansion and runs as base two.
    assign w_base  = (r_radix < MIN_RADIX) ? MIN_RADIX : r_radix;
    assign w_recip = RECIP_TBL[w_base];

    // The estimate never exceeds the true quotient and is short by at most one.
    assign w_q0    = r_prod[PROD_W-1:32];
    assign w_q0_b  = INDEX_W'(w_q0 * w_base);
    assign w_rem0  = r_num - w_q0_b;
    assign w_corr  = (w_rem0 >= INDEX_W'(w_base));
    assign w_digit = w_corr ? RADIX_W'(w_rem0 - INDEX_W'(w_base)) : RADIX_W'(w_rem0);

    assign w_shift = {r_mir, 1'b0};
    assign w_ge    = (w_shift >= {1'b0, r_pow});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RESET_RADIX;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num  <= i_index;
            r_mir  <= '0;
            r_pow  <= POW_W'(1);
            r_quot <= '0;
        end
        if (i_cmd.mul_en) begin
            r_prod  <= PROD_W'(r_num * w_recip);
            r_mir_b <= POW_W'(r_mir * w_base);
            r_pow_b <= POW_W'(r_pow * w_base);
        end
        if (i_cmd.digit_en) begin
            r_num <= w_q0 + INDEX_W'(w_corr);
            r_mir <= r_mir_b + POW_W'(w_digit);
            r_pow <= r_pow_b;
        end
        if (i_cmd.div_en) begin
            // The mirrored value doubles as the partial remainder.
            r_mir  <= w_ge ? POW_W'(w_shift - {1'b0, r_pow}) : w_shift[POW_W-1:0];
            r_quot <= {r_quot[FRAC_BITS-2:0], w_ge};
        end
    end

    assign o_sts.idx_zero = (r_num == '0);
    assign o_fraction     = FRACTION_W'(r_quot);

endmodule

// ===== sv/radical_inverse_generator_unit.sv =====
// Top level: van der Corput radical inverse, Q0.32 result.
// After a start transfer the unit extracts the k base-radix digits of the index (0 to 31),
// each by a reciprocal multiply and then a correction, then runs the division one bit a cycle;
// the o_valid strobe follows the last division bit.
// One item at a time; busy falls with the strobe and a new start is taken in that cycle.
// Synchronous active-low reset returns to idle with radix 2; the receiver cannot stall.
module radical_inverse_generator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rig_pkg::RADIX_W-1:0]    i_cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [rig_pkg::INDEX_W-1:0]    i_index,
    output logic                           o_valid,
    output logic [rig_pkg::FRACTION_W-1:0] o_fraction
);
    import rig_pkg::*;

    t_rig_cmd w_cmd;
    t_rig_sts w_sts;

    rig_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    rig_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_index    (i_index),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_fraction (o_fraction)
    );

endmodule

// ===== sv/rig_checker.sv =====
// Port-level checks for radical_inverse_generator_unit, attached by bind.
// Depends on rig_pkg for the fraction width used in the fixed latency check.
module rig_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [rig_pkg::INDEX_W-1:0]    i_index,
    input logic                           o_valid,
    input logic [rig_pkg::FRACTION_W-1:0] o_fraction
);
    import rig_pkg::*;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted transfer did not start work");

    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("work ended without a result");

    // Index zero has no digits, so its result comes after the division alone.
    a_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_index == '0)) |-> ##(FRAC_BITS + 2)
        (o_valid && (o_fraction == '0)))
        else $error("index zero gave a wrong or late result");

endmodule

bind radical_inverse_generator_unit rig_checker u_rig_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_index    (i_index),
    .o_valid    (o_valid),
    .o_fraction (o_fraction)
);
